// File: sv/ipwd_pkg.sv
// ipwd_pkg: shared constants, types and helpers for the ir pulse-width decoder
// no dependencies; imported by the interfaces, the submodules and the top level
package ipwd_pkg;

  // defaults for the top-level parameters
  localparam int unsigned CODE_BITS_DEF  = 4;
  localparam int unsigned STAMP_BITS_DEF = 16;

  // configuration register file
  localparam int unsigned REG_W     = 16;
  localparam int unsigned REG_COUNT = 6;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);

  localparam logic [IDX_W-1:0] REG_HEADER_LOW  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_HEADER_HIGH = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ZERO_LOW    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_ZERO_HIGH   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_ONE_LOW     = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_ONE_HIGH    = IDX_W'(5);

  localparam logic [REG_W-1:0] HEADER_LOW_RST  = REG_W'(300);
  localparam logic [REG_W-1:0] HEADER_HIGH_RST = REG_W'(600);
  localparam logic [REG_W-1:0] ZERO_LOW_RST    = REG_W'(100);
  localparam logic [REG_W-1:0] ZERO_HIGH_RST   = REG_W'(350);
  localparam logic [REG_W-1:0] ONE_LOW_RST     = REG_W'(650);
  localparam logic [REG_W-1:0] ONE_HIGH_RST    = REG_W'(1100);

  // pulse-width windows, all bounds exclusive
  typedef struct packed {
    logic [REG_W-1:0] header_low;
    logic [REG_W-1:0] header_high;
    logic [REG_W-1:0] zero_low;
    logic [REG_W-1:0] zero_high;
    logic [REG_W-1:0] one_low;
    logic [REG_W-1:0] one_high;
  } win_cfg_t;

  // status from the decode core
  typedef struct packed {
    logic receiving;
    logic emit;
  } core_stat_t;

  // strict window test on widths up to 32 bits
  function automatic logic in_win(input logic [31:0] w, input logic [31:0] lo,
                                  input logic [31:0] hi);
    in_win = (w > lo) && (w < hi);
  endfunction

endpackage

// File: sv/ipwd_if.sv
// ipwd_if: valid/ready channel interfaces for edge events and decoded codes
// depends on ipwd_pkg for default widths
interface ipwd_in_if #(
  parameter int unsigned STAMP_BITS = ipwd_pkg::STAMP_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] capture_time;
  logic                  line_level;

  modport source (output valid, output capture_time, output line_level, input ready);
  modport sink   (input valid, input capture_time, input line_level, output ready);
endinterface

interface ipwd_out_if #(
  parameter int unsigned CODE_BITS = ipwd_pkg::CODE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code;

  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

// File: sv/ir_pulse_width_decoder_top.sv
// ir_pulse_width_decoder_top: top level of the ir remote pulse-width decoder
// depends on ipwd_pkg, ipwd_if, ipwd_cfg_regs and ipwd_core
//
// Decodes ir remote frames from input-capture edge requests. A request with line_level 0
// records capture_time as the pulse start; one with line_level 1 measures the pulse
// width (modulo 2^STAMP_BITS) and classifies it against the header, zero and one
// windows, each exclusive at both ends. A header width opens a new frame at any time;
// zero and one widths shift bits in, first bit landing in the msb; any other width in a
// frame aborts it, and widths outside a frame are dropped. After CODE_BITS bits one
// code request goes out. The block takes one edge request per clock while no untaken
// result stalls it; a request is held in the input register, and its code is written
// to the result register when it is taken from there. A single subtract and three
// window compares lie between those registers. A pending result that is not taken stalls
// the input register, and in_ch.ready follows. The window registers are written through
// cfg_we/cfg_index/cfg_wdata in the order header_low, header_high, zero_low, zero_high,
// one_low, one_high; indexes past the list are ignored, writes belong in idle periods.
module ir_pulse_width_decoder_top #(
  parameter int unsigned CODE_BITS  = ipwd_pkg::CODE_BITS_DEF,
  parameter int unsigned STAMP_BITS = ipwd_pkg::STAMP_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ipwd_in_if.sink                    in_ch,
  ipwd_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [ipwd_pkg::IDX_W-1:0] cfg_index,
  input  logic [ipwd_pkg::REG_W-1:0] cfg_wdata
);
  import ipwd_pkg::*;

  win_cfg_t   win;
  core_stat_t stat;

  // window registers
  ipwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .win       (win)
  );

  // pulse measurement and frame decode
  ipwd_core #(
    .CODE_BITS  (CODE_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .win             (win),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_capture_time (in_ch.capture_time),
    .in_line_level   (in_ch.line_level),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_code        (out_ch.code),
    .stat            (stat)
  );

`ifndef SYNTHESIS
  // a finished frame always drops back to idle
  a_idle_after_code: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |=> !stat.receiving)
    else $error("frame still open after code was produced");

  // a new code never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("code produced while result register held an untaken code");

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule

// File: sv/ipwd_cfg_regs.sv
// ipwd_cfg_regs: write-only register file holding the six bounds of the three pulse-width windows
// depends on ipwd_pkg
module ipwd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ipwd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ipwd_pkg::REG_W-1:0]  cfg_wdata,
  output ipwd_pkg::win_cfg_t          win
);
  import ipwd_pkg::*;

  win_cfg_t win_r;
  win_cfg_t win_nxt;

  always_comb begin
    win_nxt = win_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_LOW:  win_nxt.header_low  = cfg_wdata;
        REG_HEADER_HIGH: win_nxt.header_high = cfg_wdata;
        REG_ZERO_LOW:    win_nxt.zero_low    = cfg_wdata;
        REG_ZERO_HIGH:   win_nxt.zero_high   = cfg_wdata;
        REG_ONE_LOW:     win_nxt.one_low     = cfg_wdata;
        REG_ONE_HIGH:    win_nxt.one_high    = cfg_wdata;
        default:         win_nxt = win_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.header_low  <= HEADER_LOW_RST;
      win_r.header_high <= HEADER_HIGH_RST;
      win_r.zero_low    <= ZERO_LOW_RST;
      win_r.zero_high   <= ZERO_HIGH_RST;
      win_r.one_low     <= ONE_LOW_RST;
      win_r.one_high    <= ONE_HIGH_RST;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign win = win_r;

endmodule

// File: sv/ipwd_core.sv
// ipwd_core: input register, frame state, width classification and result register
// depends on ipwd_pkg
module ipwd_core #(
  parameter int unsigned CODE_BITS  = ipwd_pkg::CODE_BITS_DEF,
  parameter int unsigned STAMP_BITS = ipwd_pkg::STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipwd_pkg::win_cfg_t    win,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [STAMP_BITS-1:0] in_capture_time,
  input  logic                  in_line_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_BITS-1:0]  out_code,
  output ipwd_pkg::core_stat_t  stat
);
  import ipwd_pkg::*;

  localparam int unsigned CNT_W = $clog2(CODE_BITS + 1);

  // input register
  logic                  s1_valid_r, s1_valid_nxt;
  logic [STAMP_BITS-1:0] s1_time_r;
  logic                  s1_level_r;

  // frame state
  logic [STAMP_BITS-1:0] pulse_start_r, pulse_start_nxt;
  logic                  receiving_r, receiving_nxt;
  logic [CNT_W-1:0]      bits_r, bits_nxt;
  logic [CODE_BITS-1:0]  code_r, code_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0]  out_code_r, out_code_nxt;

  logic                  go;
  logic                  take;
  logic [STAMP_BITS-1:0] width;
  logic [31:0]           width32;
  logic                  hdr_hit, zero_hit, one_hit;
  logic [CNT_W-1:0]      bits_inc;
  logic                  emit;

  assign go       = !out_valid_r || out_ready;
  assign take     = s1_valid_r && go;
  assign in_ready = !s1_valid_r || go;

  assign width    = s1_time_r - pulse_start_r;
  assign width32  = 32'(width);
  assign hdr_hit  = in_win(width32, 32'(win.header_low), 32'(win.header_high));
  assign zero_hit = in_win(width32, 32'(win.zero_low), 32'(win.zero_high));
  assign one_hit  = in_win(width32, 32'(win.one_low), 32'(win.one_high));
  assign bits_inc = bits_r + CNT_W'(1);

  always_comb begin
    pulse_start_nxt = pulse_start_r;
    receiving_nxt   = receiving_r;
    bits_nxt        = bits_r;
    code_nxt        = code_r;
    emit            = 1'b0;
    if (take) begin
      if (!s1_level_r) begin
        pulse_start_nxt = s1_time_r;
      end else if (hdr_hit) begin
        // header wins, even mid-frame
        receiving_nxt = 1'b1;
        bits_nxt      = '0;
        code_nxt      = '0;
      end else if (receiving_r) begin
        if (zero_hit || one_hit) begin
          code_nxt = CODE_BITS'({code_r, !zero_hit});
          bits_nxt = bits_inc;
          if (bits_inc == CNT_W'(CODE_BITS)) begin
            receiving_nxt = 1'b0;
            emit          = 1'b1;
          end
        end else begin
          // unknown width aborts, bit count and code kept
          receiving_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = code_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      pulse_start_r <= '0;
      receiving_r   <= 1'b0;
      bits_r        <= '0;
      code_r        <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      pulse_start_r <= pulse_start_nxt;
      receiving_r   <= receiving_nxt;
      bits_r        <= bits_nxt;
      code_r        <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_time_r  <= in_capture_time;
      s1_level_r <= in_line_level;
    end
    out_code_r <= out_code_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code       = out_code_r;
  assign stat.receiving = receiving_r;
  assign stat.emit      = emit;

endmodule

// File: tb/ipwd_code_checker.sv
`timescale 1ns / 1ps
// ipwd_code_checker: watches the edge, code and register ports of the ir decoder and
// predicts every code; depends on ipwd_pkg for widths, register indexes and reset values
module ipwd_code_checker
  import ipwd_pkg::*;
#(
  parameter int unsigned CODE_BITS  = CODE_BITS_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [STAMP_BITS-1:0] in_capture_time,
  input  logic                  in_line_level,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CODE_BITS-1:0]  out_code,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [REG_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    codes_pending,
  output int                    codes_seen
);

  win_cfg_t              windows;
  logic [STAMP_BITS-1:0] edge_start;
  logic                  in_frame;
  int unsigned           bit_count;
  logic [CODE_BITS-1:0]  code_acc;
  logic [CODE_BITS-1:0]  expected_codes[$];

  initial begin
    fail_count    = 0;
    codes_pending = 0;
    codes_seen    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic bit win_hit(input logic [STAMP_BITS-1:0] w, input logic [REG_W-1:0] lo,
                                 input logic [REG_W-1:0] hi);
    return (32'(w) > 32'(lo)) && (32'(w) < 32'(hi));
  endfunction

  // returns 1 when the edge completes a code
  function automatic bit decode_edge(input logic [STAMP_BITS-1:0] stamp, input logic lvl,
                                     output logic [CODE_BITS-1:0] code_out);
    logic [STAMP_BITS-1:0] width;
    code_out = '0;
    if (!lvl) begin
      edge_start = stamp;
      return 1'b0;
    end
    width = stamp - edge_start;
    if (win_hit(width, windows.header_low, windows.header_high)) begin
      in_frame  = 1'b1;
      bit_count = 0;
      code_acc  = '0;
      return 1'b0;
    end
    if (!in_frame) return 1'b0;
    if (win_hit(width, windows.zero_low, windows.zero_high)) begin
      code_acc = code_acc << 1;
    end else if (win_hit(width, windows.one_low, windows.one_high)) begin
      code_acc = (code_acc << 1) | CODE_BITS'(1);
    end else begin
      in_frame = 1'b0;
      return 1'b0;
    end
    bit_count++;
    if (bit_count >= CODE_BITS) begin
      in_frame = 1'b0;
      code_out = code_acc;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    logic [CODE_BITS-1:0] code_exp;
    logic [CODE_BITS-1:0] code_new;
    if (!rst_n) begin
      windows.header_low  = HEADER_LOW_RST;
      windows.header_high = HEADER_HIGH_RST;
      windows.zero_low    = ZERO_LOW_RST;
      windows.zero_high   = ZERO_HIGH_RST;
      windows.one_low     = ONE_LOW_RST;
      windows.one_high    = ONE_HIGH_RST;
      edge_start = '0;
      in_frame   = 1'b0;
      bit_count  = 0;
      code_acc   = '0;
      expected_codes.delete();
    end else begin
      if (out_valid && out_ready) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("code %h with none expected", out_code));
        end else begin
          code_exp = expected_codes.pop_front();
          if (out_code !== code_exp)
            report_mismatch($sformatf("code %h, expected %h", out_code, code_exp));
        end
      end
      if (in_valid && in_ready) begin
        if (decode_edge(in_capture_time, in_line_level, code_new))
          expected_codes.push_back(code_new);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER_LOW:  windows.header_low  = cfg_wdata;
          REG_HEADER_HIGH: windows.header_high = cfg_wdata;
          REG_ZERO_LOW:    windows.zero_low    = cfg_wdata;
          REG_ZERO_HIGH:   windows.zero_high   = cfg_wdata;
          REG_ONE_LOW:     windows.one_low     = cfg_wdata;
          REG_ONE_HIGH:    windows.one_high    = cfg_wdata;
          default: ;
        endcase
      end
    end
    codes_pending = expected_codes.size();
  end

endmodule

// File: tb/tb_ir_pulse_width_decoder_top.sv
`timescale 1ns / 1ps
// tb_ir_pulse_width_decoder_top: stimulus and verdict for ir_pulse_width_decoder_top
// depends on ipwd_pkg, ipwd_if, the decoder rtl and ipwd_code_checker
module tb_ir_pulse_width_decoder_top;
  import ipwd_pkg::*;

  localparam int unsigned CODE_BITS  = CODE_BITS_DEF;
  localparam int unsigned STAMP_BITS = STAMP_BITS_DEF;

  // line level carried by an edge request
  localparam logic LVL_START = 1'b0;
  localparam logic LVL_END   = 1'b1;

  // register slots past the end of the window list, must be ignored
  localparam logic [IDX_W-1:0] REG_PAST_END = IDX_W'(REG_COUNT);
  localparam logic [IDX_W-1:0] REG_TOP_SLOT = '1;

  // window modes for the random phases
  typedef enum int {WIN_DEFAULT, WIN_SPREAD, WIN_ANY, WIN_HIGH} win_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_wdata;

  int fail_count;
  int codes_pending;
  int codes_seen;

  int                    edges_sent = 0;
  bit                    idle_on    = 1'b1;
  logic [STAMP_BITS-1:0] now_tick;
  logic [STAMP_BITS-1:0] pulse_origin;
  win_cfg_t              cur_win;

  ipwd_in_if  #(.STAMP_BITS(STAMP_BITS)) in_ch ();
  ipwd_out_if #(.CODE_BITS(CODE_BITS))   out_ch ();

  ir_pulse_width_decoder_top #(
    .CODE_BITS (CODE_BITS),
    .STAMP_BITS(STAMP_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // checker sees the same pins the block sees, predicts and counts failures
  ipwd_code_checker #(
    .CODE_BITS (CODE_BITS),
    .STAMP_BITS(STAMP_BITS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_capture_time(in_ch.capture_time),
    .in_line_level  (in_ch.line_level),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_code       (out_ch.code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .codes_pending  (codes_pending),
    .codes_seen     (codes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver side: random stall bursts while idling is on, otherwise always ready
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  // one edge request; entered and left on a falling edge, with valid still high on exit
  // so the next request can follow back to back
  task automatic send_edge(input logic [STAMP_BITS-1:0] stamp, input logic lvl);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.capture_time = stamp;
    in_ch.line_level   = lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    edges_sent++;
  endtask

  // start edge, end edge after the given width, then a random quiet stretch
  task automatic send_pulse(input logic [STAMP_BITS-1:0] width);
    pulse_origin = now_tick;
    send_edge(now_tick, LVL_START);
    now_tick = now_tick + width;
    send_edge(now_tick, LVL_END);
    now_tick = now_tick + STAMP_BITS'($urandom_range(1, 3000));
  endtask

  // end edge measured from the last start, no new start before it
  task automatic send_lone_end(input logic [STAMP_BITS-1:0] width);
    send_edge(pulse_origin + width, LVL_END);
  endtask

  // sender holds off until every code is out and the pipe is empty
  task automatic hold_until_drained();
    in_ch.valid = 1'b0;
    while (codes_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  task automatic write_windows(input logic [REG_W-1:0] hl, input logic [REG_W-1:0] hh,
                               input logic [REG_W-1:0] zl, input logic [REG_W-1:0] zh,
                               input logic [REG_W-1:0] ol, input logic [REG_W-1:0] oh);
    hold_until_drained();
    put_reg(REG_HEADER_LOW,  hl);
    put_reg(REG_HEADER_HIGH, hh);
    put_reg(REG_ZERO_LOW,    zl);
    put_reg(REG_ZERO_HIGH,   zh);
    put_reg(REG_ONE_LOW,     ol);
    put_reg(REG_ONE_HIGH,    oh);
    // writes past the list must leave the windows alone
    put_reg(REG_PAST_END, REG_W'($urandom));
    put_reg(REG_TOP_SLOT, REG_W'($urandom));
    cfg_we = 1'b0;
    cur_win = '{hl, hh, zl, zh, ol, oh};
  endtask

  // a width strictly inside (lo, hi), or any width when the window is empty
  function automatic logic [STAMP_BITS-1:0] width_in(input logic [REG_W-1:0] lo,
                                                     input logic [REG_W-1:0] hi);
    int span;
    span = int'(hi) - int'(lo);
    if (span >= 2) return STAMP_BITS'(int'(lo) + $urandom_range(1, span - 1));
    return STAMP_BITS'($urandom);
  endfunction

  function automatic logic [STAMP_BITS-1:0] bit_width(input bit one);
    return one ? width_in(cur_win.one_low, cur_win.one_high)
               : width_in(cur_win.zero_low, cur_win.zero_high);
  endfunction

  task automatic pick_windows(input win_mode_t mode);
    int hl, hh, zl, zh, ol, oh;
    case (mode)
      WIN_DEFAULT: begin
        hl = int'(HEADER_LOW_RST);  hh = int'(HEADER_HIGH_RST);
        zl = int'(ZERO_LOW_RST);    zh = int'(ZERO_HIGH_RST);
        ol = int'(ONE_LOW_RST);     oh = int'(ONE_HIGH_RST);
      end
      WIN_SPREAD: begin
        hl = $urandom_range(150, 400);   hh = hl + $urandom_range(2, 300);
        zl = $urandom_range(0, 60);      zh = zl + $urandom_range(2, 90);
        ol = hh + $urandom_range(0, 200); oh = ol + $urandom_range(2, 800);
      end
      WIN_HIGH: begin
        hl = $urandom_range(60000, 62000); hh = hl + $urandom_range(2, 1000);
        zl = $urandom_range(40000, 50000); zh = zl + $urandom_range(2, 5000);
        ol = $urandom_range(63000, 65000); oh = 65535;
      end
      default: begin
        // fully random bounds, windows may be empty or overlap
        hl = $urandom_range(0, 65535); hh = $urandom_range(0, 65535);
        zl = $urandom_range(0, 65535); zh = $urandom_range(0, 65535);
        ol = $urandom_range(0, 65535); oh = $urandom_range(0, 65535);
      end
    endcase
    write_windows(REG_W'(hl), REG_W'(hh), REG_W'(zl), REG_W'(zh), REG_W'(ol), REG_W'(oh));
  endtask

  // mostly well formed frames with random bits, plus noise, stray edges,
  // mid-frame headers, lone ends and aborting widths
  task automatic run_random(input int n_edges);
    int stop_at;
    int pick;
    int sub;
    stop_at = edges_sent + n_edges;
    while (edges_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_pulse(STAMP_BITS'($urandom));
      end else if (pick == 1) begin
        now_tick = STAMP_BITS'($urandom);
        send_edge(now_tick, logic'($urandom_range(0, 1)));
      end else begin
        send_pulse(width_in(cur_win.header_low, cur_win.header_high));
        for (int b = 0; b < CODE_BITS; b++) begin
          sub = $urandom_range(0, 24);
          case (sub)
            0:       send_pulse(STAMP_BITS'($urandom));
            1:       send_pulse(width_in(cur_win.header_low, cur_win.header_high));
            2:       send_lone_end(bit_width(1'($urandom_range(0, 1))));
            default: send_pulse(bit_width(sub[0]));
          endcase
        end
      end
    end
  endtask

  initial begin
    int phase;
    in_ch.valid        = 1'b0;
    in_ch.capture_time = '0;
    in_ch.line_level   = LVL_START;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    now_tick           = '0;
    pulse_origin       = '0;
    cur_win = '{HEADER_LOW_RST, HEADER_HIGH_RST, ZERO_LOW_RST, ZERO_HIGH_RST,
                ONE_LOW_RST, ONE_HIGH_RST};
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed part on the reset windows, first edge at stamp zero
    send_pulse(16'd450);           // header opens a frame
    send_pulse(16'd101);           // zero at its lower edge
    send_pulse(16'd1099);          // one at its upper edge
    send_pulse(16'd320);           // header and zero overlap here, header wins: restart
    send_pulse(16'd300);           // zero, not a header since bounds are exclusive
    send_pulse(16'd651);           // one
    send_pulse(16'd200);           // zero
    send_lone_end(16'd900);        // end without a new start completes the code
    send_pulse(16'd5000);          // idle and no header: ignored
    send_pulse(16'd450);           // header
    send_pulse(16'd1100);          // on the one bound: aborts the frame
    send_pulse(16'd0);             // zero width while idle
    send_edge(16'hFFFF, LVL_START); // start then a repeated start overwrites it
    now_tick = 16'hFFF0;
    send_pulse(16'd450);           // header across the stamp wrap
    send_pulse(16'hFFFF);          // widest width aborts

    // extreme settings: all empty, all at the top, header over everything
    write_windows('0, '0, '0, '0, '0, '0);
    run_random(20);
    write_windows('1, '1, '1, '1, '1, '1);
    run_random(20);
    write_windows('0, '1, '0, '1, '0, '1);
    run_random(20);
    // narrow header at the top, zero window swallows nearly everything
    write_windows(16'd60000, '1, '0, 16'd60000, '0, '1);
    run_random(40);

    // random phases cycling through window shapes; the tail runs with no idling
    phase = 0;
    while (edges_sent < 1200 && phase < 60) begin
      if (edges_sent >= 1000) idle_on = 1'b0;
      pick_windows(win_mode_t'(phase % 4));
      run_random(150);
      phase++;
    end

    hold_until_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && codes_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: ir_pulse_width_decoder_top.f
sv/ipwd_pkg.sv
sv/ipwd_if.sv
sv/ipwd_cfg_regs.sv
sv/ipwd_core.sv
sv/ir_pulse_width_decoder_top.sv
tb/ipwd_code_checker.sv
tb/tb_ir_pulse_width_decoder_top.sv
